/* src/rtp_pkg.sv */
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared sizes, constant tables and control types for the rank to
// permutation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rtp_pkg;

  localparam int PERM_LEN = 8;
  localparam int RANK_W   = 16;
  localparam int IDX_W    = (PERM_LEN > 1) ? $clog2(PERM_LEN) : 1;
  localparam int DIG_W    = IDX_W;
  localparam int CNT_W    = $clog2(PERM_LEN + 1);
  localparam int VAL_W    = $clog2(PERM_LEN + 1);
  localparam int MULT_W   = RANK_W + 1;

  localparam int OUT_INDEX_W = 3;
  localparam int OUT_VALUE_W = 4;

  localparam longint MULT_SAT = longint'(1) << RANK_W;

  typedef logic [PERM_LEN-1:0][MULT_W-1:0] mult_row_t;
  typedef mult_row_t [PERM_LEN:0] mult_tbl_t;

  // row m, entry j: j*(m-1)! for j < m, saturated; unused entries saturated
  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t tbl;
    longint    f;
    longint    p;
    tbl = '1;
    f   = 1;
    for (int m = 1; m <= PERM_LEN; m++) begin
      for (int j = 0; j < PERM_LEN; j++) begin
        p = (j < m) ? longint'(j) * f : MULT_SAT;
        if (p > MULT_SAT) p = MULT_SAT;
        tbl[m][j] = MULT_W'(p);
      end
      f = f * longint'(m);
      if (f > MULT_SAT) f = MULT_SAT;
    end
    return tbl;
  endfunction

  function automatic logic [63:0] factorial(input int n);
    logic [63:0] f;
    f = 64'd1;
    for (int i = 2; i <= n; i++) begin
      f = f * 64'(i);
    end
    return f;
  endfunction

  localparam mult_tbl_t   MULT_TBL   = build_mult_tbl();
  localparam logic [63:0] RANK_LIMIT = factorial(PERM_LEN);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_INSERT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } cell_ctrl_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic [CNT_W-1:0] m;
  } dig_ctrl_t;

endpackage

`default_nettype wire

/* src/rtp_digit_unit.sv */
// ----------------------------------------------------------------------------
// rtp_digit_unit
// Extracts one mixed-radix digit per cycle while ctrl.step is high, top digit
// first, by comparing the running remainder against constant multiples of (m-1)!.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_digit_unit (
  input  wire logic                      clk,
  input  wire rtp_pkg::dig_ctrl_t        ctrl,
  input  wire logic [rtp_pkg::RANK_W-1:0] rank,
  output logic      [rtp_pkg::DIG_W-1:0]  digit
);

  logic [rtp_pkg::RANK_W-1:0] rem_r;
  logic [rtp_pkg::RANK_W-1:0] rem_nxt;
  rtp_pkg::mult_row_t         row;

  always_comb begin
    row   = rtp_pkg::MULT_TBL[ctrl.m];
    digit = '0;
    for (int j = 1; j < rtp_pkg::PERM_LEN; j++) begin
      if ({1'b0, rem_r} >= row[j]) digit = digit + rtp_pkg::DIG_W'(1);
    end
    rem_nxt = rem_r - row[digit][rtp_pkg::RANK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem_r <= rank;
    end else if (ctrl.step) begin
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/rtp_slot_cell.sv */
// ----------------------------------------------------------------------------
// rtp_slot_cell
// One position of the permutation row: holds a value, takes its left neighbor's
// value on a shift or on an insert below it, and the inserted value on an insert at it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_slot_cell (
  input  wire logic                       clk,
  input  wire rtp_pkg::cell_ctrl_t        ctrl,
  input  wire logic [rtp_pkg::IDX_W-1:0]  cell_idx,
  input  wire logic [rtp_pkg::VAL_W-1:0]  left_val,
  output logic      [rtp_pkg::VAL_W-1:0]  val
);

  logic [rtp_pkg::VAL_W-1:0] val_r;
  logic [rtp_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.mode)
      rtp_pkg::CELL_SHIFT: val_nxt = left_val;
      rtp_pkg::CELL_INSERT: begin
        if (cell_idx > ctrl.pos) begin
          val_nxt = left_val;
        end else if (cell_idx == ctrl.pos) begin
          val_nxt = ctrl.val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

/* src/rank_to_permutation_unit.sv */
// ----------------------------------------------------------------------------
// rank_to_permutation_unit
// Unranks a permutation of 1..PERM_LEN from a 16-bit rank and emits it one
// element per cycle.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The unit then extracts
// PERM_LEN digits (one compare-and-subtract step per cycle), inserts values
// 1..PERM_LEN into a shifting row of cells (one insert per cycle), and emits
// PERM_LEN results from the end of that row; the next start is taken in the
// cycle after the last result. Results appear on out_* for one cycle each
// with out_valid high and cannot be held off. A rank of PERM_LEN! or more
// still yields PERM_LEN results, with out_elem_value zero and out_rank_error
// set.
`default_nettype none

module rank_to_permutation_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [rtp_pkg::RANK_W-1:0]         in_rank,
  output logic                                    out_valid,
  output logic      [rtp_pkg::OUT_INDEX_W-1:0]    out_index,
  output logic      [rtp_pkg::OUT_VALUE_W-1:0]    out_elem_value,
  output logic                                    out_last,
  output logic                                    out_rank_error
);

  localparam int N = rtp_pkg::PERM_LEN;

  rtp_pkg::state_t           state_r, state_nxt;
  logic [rtp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      err_r;
  logic                      accept;

  logic [rtp_pkg::DIG_W-1:0] digit_r [N];
  logic [rtp_pkg::DIG_W-1:0] digit;
  logic [rtp_pkg::IDX_W-1:0] cnt_idx;

  rtp_pkg::dig_ctrl_t        dig_ctrl;
  rtp_pkg::cell_ctrl_t       cell_ctrl;
  logic [rtp_pkg::VAL_W-1:0] cell_val [N];

  logic [rtp_pkg::VAL_W+rtp_pkg::OUT_VALUE_W-1:0] val_ext;
  logic [rtp_pkg::CNT_W+rtp_pkg::OUT_INDEX_W-1:0] idx_ext;

  assign accept  = start && (state_r == rtp_pkg::ST_IDLE);
  assign cnt_idx = rtp_pkg::IDX_W'(cnt_r - rtp_pkg::CNT_W'(1));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    dig_ctrl.load  = accept;
    dig_ctrl.step  = 1'b0;
    dig_ctrl.m     = cnt_r;
    cell_ctrl.mode = rtp_pkg::CELL_HOLD;
    cell_ctrl.pos  = digit_r[cnt_idx];
    cell_ctrl.val  = rtp_pkg::VAL_W'(cnt_r);
    unique case (state_r)
      rtp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = rtp_pkg::ST_DIGIT;
          cnt_nxt   = rtp_pkg::CNT_W'(N);
        end
      end
      rtp_pkg::ST_DIGIT: begin
        dig_ctrl.step = 1'b1;
        if (cnt_r == rtp_pkg::CNT_W'(1)) begin
          state_nxt = rtp_pkg::ST_INSERT;
        end else begin
          cnt_nxt = cnt_r - rtp_pkg::CNT_W'(1);
        end
      end
      rtp_pkg::ST_INSERT: begin
        cell_ctrl.mode = rtp_pkg::CELL_INSERT;
        if (cnt_r == rtp_pkg::CNT_W'(N)) begin
          state_nxt = rtp_pkg::ST_EMIT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + rtp_pkg::CNT_W'(1);
        end
      end
      rtp_pkg::ST_EMIT: begin
        cell_ctrl.mode = rtp_pkg::CELL_SHIFT;
        if (cnt_r == rtp_pkg::CNT_W'(N - 1)) begin
          state_nxt = rtp_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + rtp_pkg::CNT_W'(1);
        end
      end
      default: state_nxt = rtp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtp_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r <= (64'(in_rank) >= rtp_pkg::RANK_LIMIT);
    end
    if (dig_ctrl.step) begin
      digit_r[cnt_idx] <= digit;
    end
  end

  rtp_digit_unit u_digit (
    .clk   (clk),
    .ctrl  (dig_ctrl),
    .rank  (in_rank),
    .digit (digit)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    rtp_slot_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl),
      .cell_idx (rtp_pkg::IDX_W'(i)),
      .left_val ((i == 0) ? '0 : cell_val[(i == 0) ? 0 : i - 1]),
      .val      (cell_val[i])
    );
  end

  assign val_ext = {{rtp_pkg::OUT_VALUE_W{1'b0}}, cell_val[N-1]};
  assign idx_ext = {{rtp_pkg::OUT_INDEX_W{1'b0}}, cnt_r};

  assign busy           = (state_r != rtp_pkg::ST_IDLE);
  assign out_valid      = (state_r == rtp_pkg::ST_EMIT);
  assign out_index      = idx_ext[rtp_pkg::OUT_INDEX_W-1:0];
  assign out_elem_value = err_r ? '0 : val_ext[rtp_pkg::OUT_VALUE_W-1:0];
  assign out_last       = out_valid && (cnt_r == rtp_pkg::CNT_W'(N - 1));
  assign out_rank_error = err_r;

  a_accept_starts_digits: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == rtp_pkg::ST_DIGIT) && (cnt_r == rtp_pkg::CNT_W'(N)))
    else $error("accepted item did not start digit extraction");

  a_insert_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtp_pkg::ST_INSERT) && !err_r |-> ({1'b0, cell_ctrl.pos} < cnt_r))
    else $error("insert position beyond current row length");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_index == $past(out_index) + 3'd1))
    else $error("result index did not advance by one");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_valid && !busy)
    else $error("results continued after last transfer");

endmodule

`default_nettype wire
